@@ rtl/bmt_pkg.sv @@
// bark masking threshold package: payload types, band tables, fixed-point constants
// no dependencies

package bmt_pkg;

	localparam int NumBands = 24;
	localparam int NumEdges = 25;
	localparam int MaxFft = 65536;
	localparam int AccW = 48;
	localparam int CntW = 17;
	localparam int EdgeW = 17;
	localparam int BandW = 5;
	localparam int LvlW = 18;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;

	localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};
	localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};
	localparam logic signed [LvlW-1:0] FloorQ88 = -18'sd20480;
	localparam logic signed [LvlW-1:0] SlopeQ88 = 18'sd4352;
	localparam logic signed [LvlW-1:0] ExtraQ88 = 18'sd102;
	localparam logic [17:0] TenLog2Q16 = 18'd197283;

	localparam logic [0:0] RegSampleRate = 1'b0;
	localparam logic [0:0] RegFftSize = 1'b1;

	typedef struct packed {
		logic [31:0] bin_power;
		logic last_bin;
	} in_beat_t;

	typedef struct packed {
		logic [BandW-1:0] band_index;
		logic signed [15:0] threshold_db;
		logic last_band;
	} out_beat_t;

	typedef struct packed {
		logic [AccW-1:0] power;
		logic [BandW-1:0] band;
		logic add;
		logic last;
	} front_beat_t;

	function automatic logic [13:0] edge_hz(input logic [4:0] i);
		logic [13:0] r;
		case (i)
			5'd0: r = 14'd20;    5'd1: r = 14'd100;   5'd2: r = 14'd200;
			5'd3: r = 14'd300;   5'd4: r = 14'd400;   5'd5: r = 14'd510;
			5'd6: r = 14'd630;   5'd7: r = 14'd770;   5'd8: r = 14'd920;
			5'd9: r = 14'd1080;  5'd10: r = 14'd1270; 5'd11: r = 14'd1480;
			5'd12: r = 14'd1720; 5'd13: r = 14'd2000; 5'd14: r = 14'd2320;
			5'd15: r = 14'd2700; 5'd16: r = 14'd3150; 5'd17: r = 14'd3700;
			5'd18: r = 14'd4400; 5'd19: r = 14'd5300; 5'd20: r = 14'd6400;
			5'd21: r = 14'd7700; 5'd22: r = 14'd9500; 5'd23: r = 14'd12000;
			default: r = 14'd15500;
		endcase
		return r;
	endfunction

	function automatic logic signed [LvlW-1:0] quiet_q88(input logic [4:0] i);
		logic signed [LvlW-1:0] r;
		case (i)
			5'd0: r = -18'sd6516;   5'd1: r = -18'sd11114;  5'd2: r = -18'sd12541;
			5'd3: r = -18'sd13211;  5'd4: r = -18'sd13623;  5'd5: r = -18'sd13918;
			5'd6: r = -18'sd14149;  5'd7: r = -18'sd14338;  5'd8: r = -18'sd14498;
			5'd9: r = -18'sd14651;  5'd10: r = -18'sd14817; 5'd11: r = -18'sd15012;
			5'd12: r = -18'sd15269; 5'd13: r = -18'sd15614; 5'd14: r = -18'sd16048;
			5'd15: r = -18'sd16476; 5'd16: r = -18'sd16625; 5'd17: r = -18'sd16174;
			5'd18: r = -18'sd15349; 5'd19: r = -18'sd14867; 5'd20: r = -18'sd14533;
			5'd21: r = -18'sd13793; 5'd22: r = -18'sd11802; default: r = -18'sd6095;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/bmt_edges.sv @@
// band edge builder: edge = min(floor(hz*F/rate), F/2), one edge per sweep step
// uses bmt_pkg; restarts its sweep on every register write

module bmt_edges
	import bmt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic restart,
	input logic [17:0] sample_rate_hz,
	input logic [16:0] fft_size,
	output logic [NumEdges-1:0][EdgeW-1:0] edges,
	output logic busy
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV = 3'b010,
		ST_STORE = 3'b100
	} ed_state_t;

	ed_state_t state_q;
	logic [4:0] idx_q;
	logic [4:0] step_q;
	logic [30:0] num_q;
	logic [30:0] rem_q;
	logic [30:0] quo_q;
	logic [EdgeW-1:0] edge_q [NumEdges];
	logic [16:0] f_eff;
	logic [EdgeW-1:0] half;
	logic [31:0] trial;
	logic [30:0] rem_sh;
	logic [30:0] prod;

	assign f_eff = (fft_size[16] && (fft_size[15:0] != '0)) ? 17'd65536 : fft_size;
	assign half = {1'b0, f_eff[16:1]};
	assign prod = {17'd0, edge_hz(idx_q)} * {14'd0, f_eff};
	assign rem_sh = {rem_q[29:0], num_q[30]};
	assign trial = {1'b0, rem_sh} - {14'd0, sample_rate_hz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DIV;
			idx_q <= '0;
			step_q <= '0;
		end else if (restart) begin
			state_q <= ST_DIV;
			idx_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) state_q <= ST_STORE;
				end
				ST_STORE: begin
					step_q <= '0;
					if (idx_q == 5'(NumEdges - 1)) state_q <= ST_IDLE;
					else begin
						idx_q <= idx_q + 5'd1;
						state_q <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			if (step_q == 5'd0) begin
				num_q <= prod;
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				num_q <= {num_q[29:0], 1'b0};
				if (!trial[31]) begin
					rem_q <= trial[30:0];
					quo_q <= {quo_q[29:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[29:0], 1'b0};
				end
			end
		end
		if (state_q == ST_STORE) begin
			if (sample_rate_hz == '0 || quo_q > 31'(half)) edge_q[idx_q] <= half;
			else edge_q[idx_q] <= quo_q[EdgeW-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < NumEdges; i++) edges[i] = edge_q[i];
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ rtl/bmt_front.sv @@
// front end: counts bins and classifies each into its bark band
// uses bmt_pkg; feeds the band queue

module bmt_front
	import bmt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic take,
	input in_beat_t in_beat,
	input logic [NumEdges-1:0][EdgeW-1:0] edges,
	output front_beat_t fb
);

	logic [CntW-1:0] bin_count_q;
	logic [BandW-1:0] band;
	logic hit;

	always_comb begin
		band = '0;
		hit = 1'b0;
		for (int b = 0; b < NumBands; b++) begin
			if (!hit && bin_count_q >= edges[b] && bin_count_q < edges[b+1]) begin
				hit = 1'b1;
				band = 5'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bin_count_q <= '0;
		else if (take) begin
			if (in_beat.last_bin) bin_count_q <= '0;
			else if (bin_count_q != CountMax) bin_count_q <= bin_count_q + 1'b1;
		end
	end

	assign fb.power = {16'd0, in_beat.bin_power};
	assign fb.band = band;
	assign fb.add = hit;
	assign fb.last = in_beat.last_bin;

endmodule

@@ rtl/bmt_queue.sv @@
// short queue between the front end and the back end
// uses bmt_pkg

module bmt_queue
	import bmt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr,
	input front_beat_t wdata,
	input logic rd,
	output front_beat_t rdata,
	output logic full,
	output logic empty
);

	front_beat_t mem_q [QDepth];
	logic [QPtrW-1:0] wp_q;
	logic [QPtrW-1:0] rp_q;
	logic [QPtrW:0] cnt_q;

	assign full = (cnt_q == (QPtrW+1)'(QDepth));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !wr)
		else $error("queue write while full");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !rd)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (QPtrW+1)'(QDepth))
		else $error("queue count overflow");

endmodule

@@ rtl/bmt_back.sv @@
// back end: band accumulation, log level, spreading and threshold output
// uses bmt_pkg; pops the band queue, drives the result register

module bmt_back
	import bmt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input front_beat_t q_data,
	output logic q_rd,
	input logic pop,
	output logic empty,
	output out_beat_t out_beat
);

	typedef enum logic [7:0] {
		ST_ACC = 8'b00000001,
		ST_INIT = 8'b00000010,
		ST_NORM = 8'b00000100,
		ST_SQR = 8'b00001000,
		ST_MUL = 8'b00010000,
		ST_RND = 8'b00100000,
		ST_SPRD = 8'b01000000,
		ST_EMIT = 8'b10000000
	} bk_state_t;

	bk_state_t state_q;
	logic [AccW-1:0] acc_q [NumBands];
	logic signed [LvlW-1:0] thr_q [NumBands];
	logic [BandW-1:0] b_q;
	logic [BandW-1:0] m_q;
	logic [5:0] e_q;
	logic [4:0] it_q;
	logic [32:0] mant_q;
	logic [15:0] frac_q;
	logic signed [22:0] lg2;
	logic signed [41:0] prod_q;
	logic signed [41:0] prod_rnd;
	logic signed [LvlW-1:0] lvl_q;
	logic out_v_q;
	out_beat_t out_q;
	logic [AccW:0] sum;
	logic [AccW-1:0] cur;
	logic [65:0] sq;
	logic [32:0] sq_sh;
	logic [5:0] msb;
	logic signed [LvlW-1:0] t_sp;
	logic signed [LvlW-1:0] d_abs;
	logic signed [LvlW-1:0] t_fin;
	logic out_free;

	assign out_free = !out_v_q || pop;
	assign cur = acc_q[q_data.band];
	assign sum = {1'b0, cur} + {1'b0, q_data.power};
	assign q_rd = (state_q == ST_ACC) && !q_empty;
	assign sq = mant_q * mant_q;
	assign sq_sh = sq[63:31];
	assign lg2 = $signed({1'b0, e_q, frac_q}) - 23'sd1048576;
	assign prod_rnd = prod_q + 42'sd8388608;

	// position of the leading one of the band sum
	always_comb begin
		msb = '0;
		for (int k = 1; k < AccW; k++)
			if (acc_q[b_q][k]) msb = 6'(k);
	end

	always_comb begin
		if (m_q >= b_q) begin
			d_abs = LvlW'(m_q - b_q);
			t_sp = lvl_q - 18'(SlopeQ88 * d_abs);
		end else begin
			d_abs = LvlW'(b_q - m_q);
			t_sp = lvl_q - 18'(SlopeQ88 * d_abs) - 18'(ExtraQ88 * (d_abs - 18'sd1));
		end
	end

	always_comb begin
		t_fin = thr_q[m_q];
		if (quiet_q88(m_q) > t_fin) t_fin = quiet_q88(m_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			out_v_q <= 1'b0;
			b_q <= '0;
			m_q <= '0;
			for (int i = 0; i < NumBands; i++) acc_q[i] <= '0;
		end else begin
			out_v_q <= ((state_q == ST_EMIT) && out_free) || (out_v_q && !pop);
			unique case (state_q)
				ST_ACC: begin
					if (!q_empty) begin
						if (q_data.add) acc_q[q_data.band] <= sum[AccW] ? AccMax : sum[AccW-1:0];
						if (q_data.last) begin
							state_q <= ST_INIT;
							m_q <= '0;
						end
					end
				end
				ST_INIT: begin
					m_q <= m_q + 1'b1;
					if (m_q == 5'(NumBands - 1)) begin
						b_q <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (acc_q[b_q] == '0) begin
						if (b_q == 5'(NumBands - 1)) begin
							m_q <= '0;
							state_q <= ST_EMIT;
						end else b_q <= b_q + 1'b1;
					end else state_q <= ST_SQR;
				end
				ST_SQR: begin
					if (it_q == 5'd16) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_RND;
				ST_RND: begin
					m_q <= '0;
					state_q <= ST_SPRD;
				end
				ST_SPRD: begin
					if (m_q == 5'(NumBands - 1)) begin
						m_q <= '0;
						if (b_q == 5'(NumBands - 1)) state_q <= ST_EMIT;
						else begin
							b_q <= b_q + 1'b1;
							state_q <= ST_NORM;
						end
					end else m_q <= m_q + 1'b1;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_q <= m_q + 1'b1;
						if (m_q == 5'(NumBands - 1)) begin
							for (int i = 0; i < NumBands; i++) acc_q[i] <= '0;
							state_q <= ST_ACC;
						end
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_INIT: thr_q[m_q] <= FloorQ88;
			ST_NORM: begin
				e_q <= msb;
				it_q <= '0;
				frac_q <= '0;
			end
			ST_SQR: begin
				if (it_q == 5'd0) begin
					if (e_q <= 6'd31) mant_q <= 33'(acc_q[b_q] << (6'd31 - e_q));
					else mant_q <= 33'(acc_q[b_q] >> (e_q - 6'd31));
					it_q <= 5'd1;
				end else begin
					it_q <= it_q + 5'd1;
					if (sq_sh[32]) begin
						mant_q <= {1'b0, sq_sh[32:1]};
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						mant_q <= sq_sh;
						frac_q <= {frac_q[14:0], 1'b0};
					end
				end
			end
			ST_MUL: begin
				prod_q <= lg2 * $signed({1'b0, TenLog2Q16});
			end
			ST_RND: begin
				lvl_q <= prod_rnd[41:24];
			end
			default: begin
			end
		endcase
		if (state_q == ST_SPRD && t_sp > thr_q[m_q]) thr_q[m_q] <= t_sp;
		if (state_q == ST_EMIT && out_free) begin
			out_q.band_index <= m_q;
			out_q.last_band <= (m_q == 5'(NumBands - 1));
			if (t_fin > 18'sd32767) out_q.threshold_db <= 16'sh7FFF;
			else if (t_fin < -18'sd32768) out_q.threshold_db <= 16'sh8000;
			else out_q.threshold_db <= t_fin[15:0];
		end
	end

	assign empty = !out_v_q;
	assign out_beat = out_q;

	assert property (@(posedge clk) disable iff (!arst_n) q_rd |-> state_q == ST_ACC)
		else $error("queue read outside accumulate");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pop) |=> $stable(out_q))
		else $error("result changed while held");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQR) |-> (it_q <= 5'd16))
		else $error("log iteration overrun");

endmodule

@@ rtl/bark_masking_threshold_top.sv @@
// bark masking threshold top: edge builder, front end, band queue, back end
// uses bmt_pkg, bmt_edges, bmt_front, bmt_queue, bmt_back
//
// input: push a beat (bin_power UQ16.16, last_bin) when full is low, bins
// in ascending order from bin 0; one bin per cycle is sustained while the back end accumulates.
// output: while empty is low the oldest threshold beat is shown; pop takes it.
// a last bin yields 24 beats, bands 0..23, last_band on band 23.
// after a last bin, the back end sets the floor in every band, then for each
// nonzero band normalizes, loads, runs 16 squaring steps, multiplies, rounds
// and spreads over all 24 bands, and skips each empty band; then it moves one
// beat per cycle into a one-entry result register while that register is free.
// when pop stalls, the back end holds, the 4-entry band queue fills and
// full rises; no beat is lost.
// reset: registers return to 48000 Hz and 2048; band edges are rebuilt one at
// a time (one division bit per cycle, then a store), full is high meanwhile.
// each register write restarts that rebuild.

module bark_masking_threshold_top
	import bmt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_beat_t in_beat,
	output logic empty,
	input logic pop,
	output out_beat_t out_beat,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [17:0] cfg_data
);

	logic [17:0] rate_q;
	logic [16:0] fft_q;
	logic [NumEdges-1:0][EdgeW-1:0] edges;
	logic ed_busy;
	logic q_full;
	logic q_empty;
	logic q_rd;
	logic take;
	front_beat_t fb;
	front_beat_t qb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 18'd48000;
			fft_q <= 17'd2048;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegSampleRate: rate_q <= cfg_data;
				RegFftSize: fft_q <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	assign full = q_full || ed_busy;
	assign take = push && !full;

	bmt_edges u_edges (
		.clk(clk), .arst_n(arst_n), .restart(cfg_we),
		.sample_rate_hz(rate_q), .fft_size(fft_q),
		.edges(edges), .busy(ed_busy)
	);

	bmt_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .in_beat(in_beat),
		.edges(edges), .fb(fb)
	);

	bmt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(take), .wdata(fb), .rd(q_rd),
		.rdata(qb), .full(q_full), .empty(q_empty)
	);

	bmt_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(qb),
		.q_rd(q_rd), .pop(pop), .empty(empty), .out_beat(out_beat)
	);

endmodule

@@ test/testbench.sv @@
// testbench for bark_masking_threshold_top: directed table then random frames,
// every threshold beat checked against a band-threshold predictor; uses bmt_pkg
`timescale 1ns / 100ps

module testbench;
	import bmt_pkg::*;

	localparam int QuietLim = 200000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_beat_t in_beat;
	logic empty;
	logic pop;
	out_beat_t out_beat;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [17:0] cfg_data;

	bark_masking_threshold_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_beat(in_beat),
		.empty(empty), .pop(pop), .out_beat(out_beat), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [17:0] rate_q;
	logic [16:0] fsize_q;
	logic [47:0] sums_q [NumBands];
	logic [16:0] edges_q [NumEdges];
	logic [16:0] bins_q;

	out_beat_t thr_pending [$];
	int errors;
	int beats_out;
	int frames;
	int idle_cycles;
	bit hold_long;

	typedef struct {
		logic [31:0] p;
		logic lb;
		bit has_exp;
		logic signed [15:0] exp0;
	} row_t;
	row_t rows [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int hz_of(input int i);
		case (i)
			0: return 20; 1: return 100; 2: return 200; 3: return 300; 4: return 400;
			5: return 510; 6: return 630; 7: return 770; 8: return 920; 9: return 1080;
			10: return 1270; 11: return 1480; 12: return 1720; 13: return 2000;
			14: return 2320; 15: return 2700; 16: return 3150; 17: return 3700;
			18: return 4400; 19: return 5300; 20: return 6400; 21: return 7700;
			22: return 9500; 23: return 12000; default: return 15500;
		endcase
	endfunction

	function automatic int quiet_of(input int i);
		int t [24] = '{-6516, -11114, -12541, -13211, -13623, -13918, -14149, -14338,
			-14498, -14651, -14817, -15012, -15269, -15614, -16048, -16476,
			-16625, -16174, -15349, -14867, -14533, -13793, -11802, -6095};
		return t[i];
	endfunction

	task automatic rebuild_edges();
		longint unsigned f, half, e;
		f = fsize_q;
		if (f > MaxFft) f = MaxFft;
		half = f >> 1;
		for (int i = 0; i < NumEdges; i++) begin
			e = half;
			if (rate_q != 0) e = (longint'(hz_of(i)) * f) / rate_q;
			if (e > half) e = half;
			edges_q[i] = e[16:0];
		end
	endtask

	function automatic int band_level(input logic [47:0] acc);
		int unsigned ex;
		logic [127:0] m;
		int unsigned fr;
		longint l, prod;
		longint unsigned u;
		ex = 0;
		fr = 0;
		while (ex < 47 && (acc >> (ex + 1)) != 0) ex++;
		m = (ex <= 31) ? (128'(acc) << (31 - ex)) : (128'(acc) >> (ex - 31));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			fr = fr << 1;
			if (m >= (128'd1 << 32)) begin
				fr = fr | 1;
				m = m >> 1;
			end
		end
		l = longint'((longint'(ex) << 16) | fr) - (longint'(16) << 16);
		prod = l * 197283;
		u = prod + (longint'(1) << 40) + (longint'(1) << 23);
		return int'(longint'(u >> 24) - (longint'(1) << 16));
	endfunction

	task automatic predict_bin(input logic [31:0] p, input logic lb);
		logic [48:0] s;
		int thr [NumBands];
		int lvl, t, d;
		out_beat_t ob;
		for (int b = 0; b < NumBands; b++)
			if (bins_q >= edges_q[b] && bins_q < edges_q[b+1]) begin
				s = sums_q[b] + p;
				sums_q[b] = s[48] ? AccMax : s[47:0];
			end
		if (bins_q != CountMax) bins_q++;
		if (!lb) return;
		for (int m = 0; m < NumBands; m++) thr[m] = -20480;
		for (int b = 0; b < NumBands; b++) begin
			if (sums_q[b] == 0) continue;
			lvl = band_level(sums_q[b]);
			for (int m = 0; m < NumBands; m++) begin
				d = (m >= b) ? m - b : b - m;
				t = lvl - 4352 * d - ((m < b) ? 102 * (d - 1) : 0);
				if (t > thr[m]) thr[m] = t;
			end
		end
		for (int m = 0; m < NumBands; m++) begin
			t = thr[m];
			if (quiet_of(m) > t) t = quiet_of(m);
			if (t > 32767) t = 32767;
			if (t < -32768) t = -32768;
			ob.band_index = m[4:0];
			ob.threshold_db = t[15:0];
			ob.last_band = (m == NumBands - 1);
			thr_pending.push_back(ob);
		end
		for (int b = 0; b < NumBands; b++) sums_q[b] = '0;
		bins_q = '0;
		frames++;
	endtask

	task automatic report(input string what, input out_beat_t got, input out_beat_t want);
		errors++;
		$display("mismatch %s: got band %0d thr %0d last %0b, want band %0d thr %0d last %0b",
			what, got.band_index, got.threshold_db, got.last_band,
			want.band_index, want.threshold_db, want.last_band);
	endtask

	// result side: random pop gaps, one long hold-off on request
	initial begin
		int g;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				pop <= 1'b0;
				for (int i = 0; i < 400; i++) @(posedge clk);
				hold_long = 0;
			end
			g = $urandom_range(0, 9);
			pop <= (g < 6);
			if (g == 9 && $urandom_range(0, 4) == 0)
				repeat ($urandom_range(5, 40)) @(posedge clk);
		end
	end

	// checker
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && pop && !empty) begin
			beats_out++;
			if (thr_pending.size() == 0) begin
				errors++;
				$display("unexpected threshold beat, band %0d", out_beat.band_index);
			end else begin
				want = thr_pending.pop_front();
				if (out_beat.band_index !== want.band_index) report("band_index", out_beat, want);
				if (out_beat.threshold_db !== want.threshold_db)
					report("threshold_db", out_beat, want);
				if (out_beat.last_band !== want.last_band) report("last_band", out_beat, want);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > QuietLim) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_bin(input logic [31:0] p, input logic lb, input bit gaps);
		int g;
		if (gaps) begin
			g = $urandom_range(0, 19);
			if (g >= 14) begin
				push <= 1'b0;
				repeat ((g == 19) ? $urandom_range(20, 60) : $urandom_range(1, 3))
					@(posedge clk);
			end
		end
		push <= 1'b1;
		in_beat.bin_power <= p;
		in_beat.last_bin <= lb;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_bin(p, lb);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (thr_pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [17:0] v);
		drain();
		repeat (30) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegSampleRate) rate_q = v;
		else fsize_q = v[16:0];
		rebuild_edges();
	endtask

	function automatic logic [31:0] rnd_power();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_frame(input int nbins, input bit gaps);
		for (int i = 0; i < nbins; i++)
			send_bin(rnd_power(), i == nbins - 1, gaps);
	endtask

	initial begin
		int sent;
		row_t r;
		errors = 0;
		beats_out = 0;
		frames = 0;
		idle_cycles = 0;
		hold_long = 0;
		arst_n = 1'b0;
		push = 1'b0;
		in_beat = '0;
		cfg_we = 1'b0;
		cfg_index = RegSampleRate;
		cfg_data = '0;
		rate_q = 18'd48000;
		fsize_q = 17'd2048;
		bins_q = '0;
		for (int b = 0; b < NumBands; b++) sums_q[b] = '0;
		rebuild_edges();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small fft so frames are short
		write_reg(RegFftSize, 18'd64);
		write_reg(RegSampleRate, 18'd8000);
		// directed table: empty frame shows the quiet threshold in band 0
		rows.push_back('{32'd0, 1'b1, 1, -16'sd6516});
		rows.push_back('{32'd0, 1'b1, 0, 0});
		rows.push_back('{32'hFFFF_FFFF, 1'b0, 0, 0});
		rows.push_back('{32'hFFFF_FFFF, 1'b0, 0, 0});
		rows.push_back('{32'h0001_0000, 1'b0, 0, 0});
		rows.push_back('{32'd1, 1'b0, 0, 0});
		rows.push_back('{32'hFFFF_FFFF, 1'b0, 0, 0});
		rows.push_back('{32'h8000_0000, 1'b0, 0, 0});
		rows.push_back('{32'h5555_5555, 1'b0, 0, 0});
		rows.push_back('{32'hAAAA_AAAA, 1'b1, 0, 0});
		rows.push_back('{32'd1, 1'b1, 0, 0});
		foreach (rows[i]) begin
			r = rows[i];
			if (r.has_exp && r.lb) begin
				// band 0 of this frame must match the typed value as well
				send_bin(r.p, r.lb, 0);
				if (thr_pending[thr_pending.size()-24].threshold_db !== r.exp0) begin
					errors++;
					$display("directed row %0d: band 0 threshold off", i);
				end
			end else send_bin(r.p, r.lb, 0);
		end
		// zero rate, oversized fft, max rate
		write_reg(RegSampleRate, 18'd0);
		random_frame(8, 0);
		write_reg(RegFftSize, 18'h1FFFF);
		write_reg(RegSampleRate, 18'h3FFFF);
		random_frame(20, 0);
		write_reg(RegSampleRate, 18'd192000);
		write_reg(RegFftSize, 18'd128);

		// random part; long pop hold-off while bins keep coming
		sent = 0;
		hold_long = 1;
		while (sent < 380) begin
			int n;
			n = $urandom_range(1, 70);
			random_frame(n, 1);
			sent += n;
			if ($urandom_range(0, 3) == 0) drain();
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(RegSampleRate, 18'(18'd8000 + $urandom_range(0, 184000)));
					1: write_reg(RegSampleRate, 18'd48000);
					2: write_reg(RegFftSize, 18'd64 << $urandom_range(0, 2));
					default: write_reg(RegFftSize, 18'(18'd64 + $urandom_range(0, 200)));
				endcase
			end
		end
		// let the last results out
		drain();
		push <= 1'b0;
		while (thr_pending.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		$display("covered %0d frames, %0d threshold beats, rates 0..262143, fft 64..131071",
			frames, beats_out);
		if (errors == 0 && thr_pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
